/* sv/trt_pkg.sv */
package trt_pkg;

    localparam int COORD_BITS = 12;
    localparam int OUT_BITS   = 12;
    localparam int MAX_REPORTS = 4;

    localparam logic [OUT_BITS-1:0] COORD_MASK = OUT_BITS'((33'd1 << COORD_BITS) - 33'd1);

    // touch kind kept between polls
    localparam logic [1:0] KIND_NONE   = 2'd0;
    localparam logic [1:0] KIND_SINGLE = 2'd1;
    localparam logic [1:0] KIND_MULTI  = 2'd2;

    // type nibble of the info register
    localparam logic [3:0] TYPE_NONE   = 4'd0;
    localparam logic [3:0] TYPE_SINGLE = 4'd1;
    localparam logic [3:0] TYPE_MULTI  = 4'd2;

    // nibble masks of the packed high coordinate byte
    localparam logic [7:0] HI_NIB_MASK = 8'hf0;
    localparam logic [7:0] LO_NIB_MASK = 8'h0f;

    typedef logic [OUT_BITS-1:0] t_coord;

    typedef struct packed {
        t_coord x;
        t_coord y;
        logic   pressed;
        logic   frame_end;
    } t_report;

    // all reports caused by one poll, packed from slot zero upward
    typedef struct packed {
        t_report [MAX_REPORTS-1:0] rep;
        logic [2:0]                count;
    } t_batch;

endpackage

/* sv/trt_front.sv */
module trt_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_accept,
    input  logic            i_pen_down,
    input  logic            i_new_event,
    input  logic            i_read_ok,
    input  logic [7:0]      i_info_byte,
    input  logic [7:0]      i_xy_high,
    input  logic [7:0]      i_x_low,
    input  logic [7:0]      i_y_low,
    input  logic [7:0]      i_xy2_high,
    input  logic [7:0]      i_x2_low,
    input  logic [7:0]      i_y2_low,
    output logic            o_push,
    output trt_pkg::t_batch o_batch
);
    import trt_pkg::*;

    logic       r_active, n_active;
    logic [1:0] r_kind, n_kind;
    t_coord     r_prev_x [2];
    t_coord     r_prev_y [2];
    t_coord     n_prev_x [2];
    t_coord     n_prev_y [2];
    logic [1:0] r_prev_valid, n_prev_valid;

    t_report    cand     [MAX_REPORTS];
    logic [MAX_REPORTS-1:0] cand_vld;
    logic       release_first;
    logic [3:0] kind_type;
    t_coord     x1, y1, x2, y2;
    logic [2:0] cnt;

    // classify the poll and build candidate reports
    always_comb begin
        n_active     = r_active;
        n_kind       = r_kind;
        n_prev_x     = r_prev_x;
        n_prev_y     = r_prev_y;
        n_prev_valid = r_prev_valid;
        cand_vld     = '0;
        for (int i = 0; i < MAX_REPORTS; i++) begin
            cand[i] = '0;
        end

        kind_type = i_info_byte[3:0] & LO_NIB_MASK[3:0];
        x1 = COORD_MASK & {i_xy_high[7:4], i_x_low};
        y1 = COORD_MASK & {i_xy_high[3:0], i_y_low};
        x2 = '0;
        y2 = '0;

        // release remembered fingers on a new interrupt
        release_first = i_pen_down && i_new_event && r_active;
        if (release_first) begin
            if (r_kind == KIND_MULTI) begin
                cand_vld[0] = r_prev_valid[0];
                cand[0] = '{x: r_prev_x[0], y: r_prev_y[0], pressed: 1'b0,
                            frame_end: !r_prev_valid[1]};
                cand_vld[1] = r_prev_valid[1];
                cand[1] = '{x: r_prev_x[1], y: r_prev_y[1], pressed: 1'b0,
                            frame_end: 1'b1};
                n_kind       = KIND_NONE;
                n_prev_valid = 2'b00;
            end else begin
                cand_vld[0] = r_prev_valid[0];
                cand[0] = '{x: r_prev_x[0], y: r_prev_y[0], pressed: 1'b0,
                            frame_end: 1'b1};
                n_prev_valid[0] = 1'b0;
            end
            n_active = 1'b0;
        end

        // decode the register block
        if (i_read_ok) begin
            if (kind_type == TYPE_MULTI) begin
                n_kind = KIND_MULTI;
                x2 = COORD_MASK & {4'((i_xy2_high & HI_NIB_MASK) >> 4), i_x2_low};
                y2 = COORD_MASK & {4'(i_xy2_high & LO_NIB_MASK), i_y2_low};
            end
            if (i_pen_down) begin
                if (kind_type != TYPE_NONE) begin
                    n_active = 1'b1;
                    if (kind_type == TYPE_MULTI) begin
                        cand_vld[2] = 1'b1;
                        cand[2] = '{x: x1, y: y1, pressed: 1'b1, frame_end: 1'b0};
                        cand_vld[3] = 1'b1;
                        cand[3] = '{x: x2, y: y2, pressed: 1'b1, frame_end: 1'b1};
                        n_prev_x[0] = x1;
                        n_prev_y[0] = y1;
                        n_prev_x[1] = x2;
                        n_prev_y[1] = y2;
                        n_prev_valid = 2'b11;
                    end else if (kind_type == TYPE_SINGLE) begin
                        cand_vld[2] = 1'b1;
                        cand[2] = '{x: x1, y: y1, pressed: 1'b1, frame_end: 1'b1};
                        n_kind = KIND_SINGLE;
                        n_prev_x[0] = x1;
                        n_prev_y[0] = y1;
                        n_prev_valid[0] = 1'b1;
                    end
                end
            end else if (r_active) begin
                // pen lifted: release
                if (n_kind == KIND_MULTI) begin
                    cand_vld[2] = r_prev_valid[0];
                    cand[2] = '{x: r_prev_x[0], y: r_prev_y[0], pressed: 1'b0,
                                frame_end: !r_prev_valid[1]};
                    cand_vld[3] = r_prev_valid[1];
                    cand[3] = '{x: r_prev_x[1], y: r_prev_y[1], pressed: 1'b0,
                                frame_end: 1'b1};
                    n_kind       = KIND_NONE;
                    n_prev_valid = 2'b00;
                end else begin
                    cand_vld[2] = 1'b1;
                    cand[2] = '{x: x1, y: y1, pressed: 1'b0, frame_end: 1'b1};
                end
                n_active = 1'b0;
            end
        end
    end

    // pack the candidates into consecutive slots
    always_comb begin
        o_batch = '0;
        cnt     = '0;
        for (int i = 0; i < MAX_REPORTS; i++) begin
            if (cand_vld[i]) begin
                o_batch.rep[cnt[1:0]] = cand[i];
                cnt = cnt + 3'd1;
            end
        end
        o_batch.count = cnt;
    end

    assign o_push = i_accept && (cnt != 3'd0);

    // update the tracking state on each accepted poll
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active     <= 1'b0;
            r_kind       <= KIND_NONE;
            r_prev_x     <= '{default: '0};
            r_prev_y     <= '{default: '0};
            r_prev_valid <= 2'b11;
        end else if (i_accept) begin
            r_active     <= n_active;
            r_kind       <= n_kind;
            r_prev_x     <= n_prev_x;
            r_prev_y     <= n_prev_y;
            r_prev_valid <= n_prev_valid;
        end
    end

endmodule

/* sv/trt_queue.sv */
module trt_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  trt_pkg::t_batch i_batch,
    output logic            o_ready,
    input  logic            i_pop,
    output logic            o_valid,
    output trt_pkg::t_batch o_head
);
    import trt_pkg::*;

    t_batch     r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_cnt;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_head  = r_mem[r_rd_ptr];

    // store pushed batches
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_batch;
        end
    end

    // advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

`ifndef SYNTHESIS
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 2'd2)
        else $error("queue fill count out of range");
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (o_ready || i_pop))
        else $error("push into a full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("pop from an empty queue");
    a_batch_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (i_batch.count != 3'd0 && i_batch.count <= 3'd4))
        else $error("pushed batch with bad report count");
`endif

endmodule

/* sv/trt_back.sv */
module trt_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_head_valid,
    input  trt_pkg::t_batch i_head,
    output logic            o_pop,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output trt_pkg::t_report o_report,
    output logic            o_last
);
    import trt_pkg::*;

    logic [1:0] r_idx;
    logic       r_valid;
    t_report    r_report;
    logic       r_last;
    logic       load;
    logic       sel_last;

    // one report a transaction from the head batch
    assign load     = i_head_valid && (!r_valid || i_out_ready);
    assign sel_last = ({1'b0, r_idx} == (i_head.count - 3'd1));
    assign o_pop    = load && sel_last;

    // hold the output register until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_idx   <= sel_last ? 2'd0 : r_idx + 2'd1;
            end else if (i_out_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_report <= i_head.rep[r_idx];
            r_last   <= sel_last;
        end
    end

    assign o_out_valid = r_valid;
    assign o_report    = r_report;
    assign o_last      = r_last;

endmodule

/* sv/touch_report_tracker.sv */
// Touch report tracker: turns controller polls into finger reports.
// Input channel: i_in_valid / o_in_ready carry one poll (pen level, new
// interrupt flag, read status and the register bytes) per transaction.
// Output channel: o_out_valid / i_out_ready carry one finger report per
// transaction: coordinates, press or release, frame end, and o_last on the
// final report caused by a poll. A poll causing no report gives nothing.
// Path: with the queue and output register empty, the first report of a
// poll is written into a queue entry when the poll is accepted and is then
// loaded into the output register.
// Throughput: the front stage takes one poll per cycle while its two-entry
// batch queue has room; the back stage sends one report per cycle while
// i_out_ready is high, so the reports of a poll (up to four) leave one at a
// time through the single output register.
// Reset: clears the touch state (no touch, both fingers marked valid at the
// origin) and empties the queue and the output register.
// Stall: when i_out_ready is low the output register holds its report, the
// queue fills, and o_in_ready drops once both queue entries are taken.
module touch_report_tracker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_pen_down,
    input  logic        i_new_event,
    input  logic        i_read_ok,
    input  logic [7:0]  i_info_byte,
    input  logic [7:0]  i_xy_high,
    input  logic [7:0]  i_x_low,
    input  logic [7:0]  i_y_low,
    input  logic [7:0]  i_xy2_high,
    input  logic [7:0]  i_x2_low,
    input  logic [7:0]  i_y2_low,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [11:0] o_finger_x,
    output logic [11:0] o_finger_y,
    output logic        o_pressed,
    output logic        o_frame_end,
    output logic        o_last
);
    import trt_pkg::*;

    logic    accept;
    logic    push;
    t_batch  push_batch;
    logic    q_ready;
    logic    q_valid;
    t_batch  q_head;
    logic    pop;
    t_report report;

    assign o_in_ready = q_ready;
    assign accept     = i_in_valid && q_ready;

    trt_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_pen_down  (i_pen_down),
        .i_new_event (i_new_event),
        .i_read_ok   (i_read_ok),
        .i_info_byte (i_info_byte),
        .i_xy_high   (i_xy_high),
        .i_x_low     (i_x_low),
        .i_y_low     (i_y_low),
        .i_xy2_high  (i_xy2_high),
        .i_x2_low    (i_x2_low),
        .i_y2_low    (i_y2_low),
        .o_push      (push),
        .o_batch     (push_batch)
    );

    trt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_batch (push_batch),
        .o_ready (q_ready),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_head  (q_head)
    );

    trt_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (q_valid),
        .i_head       (q_head),
        .o_pop        (pop),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_report     (report),
        .o_last       (o_last)
    );

    assign o_finger_x  = report.x;
    assign o_finger_y  = report.y;
    assign o_pressed   = report.pressed;
    assign o_frame_end = report.frame_end;

endmodule
